@@ rtl/ubpm_pkg.sv @@
`timescale 1ns / 1ps

package ubpm_pkg;

	// Field widths
	localparam int RUN_RATE_W = 8;
	localparam int ADC_W      = 12;
	localparam int MV_W       = 13;
	localparam int LIMIT_W    = 4;
	localparam int RATE_W     = 7;
	localparam int ACTION_W   = 3;
	localparam int STATE_W    = 2;
	localparam int CNT_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Sampling rate limits
	localparam logic [RATE_W-1:0] RATE_MIN = 7'd10;
	localparam logic [RATE_W-1:0] RATE_MAX = 7'd100;

	// Millivolt scaling: mv = floor(adc * 181 / 125), the 1.448 divider ratio.
	// The divide by 125 is a multiply by ceil(2^26 / 125) and a shift, exact
	// for every 20-bit numerator that a 12-bit sample can give.
	localparam int                  MV_NUM_W    = 8;
	localparam logic [MV_NUM_W-1:0] MV_NUM      = 8'd181;
	localparam int                  PROD_W      = ADC_W + MV_NUM_W;
	localparam int                  RECIP_W     = 20;
	localparam logic [RECIP_W-1:0]  MV_RECIP    = 20'd536871;
	localparam int                  RECIP_SHIFT = 26;
	localparam int                  SCALED_W    = PROD_W + RECIP_W;

	// Divide by ten for rates up to 100: x * 205 >> 11
	localparam int                 DIV10_W     = 8;
	localparam logic [DIV10_W-1:0] DIV10_MUL   = 8'd205;
	localparam int                 DIV10_SHIFT = 11;

	// Charge states
	localparam logic [STATE_W-1:0] ST_INIT = 2'd0;
	localparam logic [STATE_W-1:0] ST_USB  = 2'd1;
	localparam logic [STATE_W-1:0] ST_BAT  = 2'd2;
	localparam logic [STATE_W-1:0] ST_FULL = 2'd3;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_NONE        = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_RESTART     = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_CHARGE      = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_USB_REPORT  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_USB_BREATHE = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_BAT_REPORT  = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_BAT_FAULT   = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_BAT_OK      = 3'd7;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_USB_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BATTERY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIMIT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OK_LIMIT      = 2'd3;

	// Configuration reset values
	localparam logic [MV_W-1:0]    USB_THRESHOLD_RST = 13'd4500;
	localparam logic [MV_W-1:0]    MIN_BATTERY_RST   = 13'd3300;
	localparam logic [LIMIT_W-1:0] FAULT_LIMIT_RST   = 4'd10;
	localparam logic [LIMIT_W-1:0] OK_LIMIT_RST      = 4'd10;

	// Clamp the requested rate to 10..100 Hz
	function automatic logic [RATE_W-1:0] clamp_rate(input logic [RUN_RATE_W-1:0] rate);
		logic [RUN_RATE_W-1:0] res;
		res = rate;
		if (rate > {1'b0, RATE_MAX}) begin
			res = {1'b0, RATE_MAX};
		end else if (rate < {1'b0, RATE_MIN}) begin
			res = {1'b0, RATE_MIN};
		end
		return res[RATE_W-1:0];
	endfunction

	// Ticks between power checks: rate / 10
	function automatic logic [CNT_W-1:0] check_period(input logic [RATE_W-1:0] rate);
		logic [RATE_W+DIV10_W-1:0] prod;
		prod = {{DIV10_W{1'b0}}, rate} * {{RATE_W{1'b0}}, DIV10_MUL};
		return prod[DIV10_SHIFT +: CNT_W];
	endfunction

endpackage

@@ rtl/usb_battery_power_monitor_top.sv @@
// USB / battery power monitor. Each input transaction is one sampling tick
// carrying the requested rate, a 12-bit battery sample and the cable-detect
// level; each tick returns exactly one result transaction with an action code,
// the clamped rate, a rate-change flag and, on every rate/10-th tick, the
// battery voltage in millivolts and the outcome of the power check. The block
// takes one tick per clock cycle while results are taken, and each tick
// passes a first and a second register stage: the first stage clamps the
// rate and forms adc*181, the second finishes the millivolt scaling and
// steps the charge state, counters and rate history, which are updated
// once per tick. The output register lets a new tick enter while a
// finished result still waits. Configuration writes take effect at once
// and must only be issued while no tick is in flight.
`timescale 1ns / 1ps

module usb_battery_power_monitor_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// tick channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ubpm_pkg::RUN_RATE_W-1:0]    run_rate,
	input  logic [ubpm_pkg::ADC_W-1:0]         battery_adc,
	input  logic                               cable_low,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ubpm_pkg::ACTION_W-1:0]      action,
	output logic                               power_checked,
	output logic                               rate_changed,
	output logic [ubpm_pkg::RATE_W-1:0]        clamped_rate,
	output logic [ubpm_pkg::MV_W-1:0]          battery_mv,
	output logic [ubpm_pkg::STATE_W-1:0]       charge_state_out,
	// configuration
	input  logic                               cfg_we,
	input  logic [ubpm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ubpm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import ubpm_pkg::*;

	// Configuration registers
	logic [MV_W-1:0]    usb_threshold_q;
	logic [MV_W-1:0]    min_battery_q;
	logic [LIMIT_W-1:0] fault_limit_q;
	logic [LIMIT_W-1:0] ok_limit_q;

	// Stage 1 registers
	logic               valid_s1;
	logic [RATE_W-1:0]  rate_s1;
	logic [CNT_W-1:0]   period_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic               cable_s1;

	// Monitor state
	logic [STATE_W-1:0] charge_q;
	logic [CNT_W-1:0]   tick_q;
	logic [CNT_W-1:0]   low_q;
	logic [CNT_W-1:0]   ok_q;
	logic [RATE_W-1:0]  last_rate_q;

	// Stage 2 (result) registers
	logic                valid_s2;
	logic [ACTION_W-1:0] action_s2;
	logic                checked_s2;
	logic                changed_s2;
	logic [RATE_W-1:0]   rate_s2;
	logic [MV_W-1:0]     mv_s2;
	logic [STATE_W-1:0]  charge_s2;

	// Next-state and stage 2 logic
	logic                load_s1;
	logic                adv_s2;
	logic [PROD_W-1:0]   prod_in;
	logic [SCALED_W-1:0] scaled;
	logic [MV_W-1:0]     mv_calc;
	logic [CNT_W-1:0]    tick_inc;
	logic                check;
	logic                usb_seen;
	logic [ACTION_W-1:0] action_d;
	logic [STATE_W-1:0]  charge_d;
	logic [CNT_W-1:0]    tick_d;
	logic [CNT_W-1:0]    low_d;
	logic [CNT_W-1:0]    ok_d;
	logic [RATE_W-1:0]   last_rate_d;

	// Handshake: stage 1 moves on whenever the result register is empty or being read
	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;
	assign load_s1  = in_valid && in_ready;

	// First half of the millivolt scaling
	assign prod_in = {{MV_NUM_W{1'b0}}, battery_adc} * {{ADC_W{1'b0}}, MV_NUM};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usb_threshold_q <= USB_THRESHOLD_RST;
			min_battery_q   <= MIN_BATTERY_RST;
			fault_limit_q   <= FAULT_LIMIT_RST;
			ok_limit_q      <= OK_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_USB_THRESHOLD: usb_threshold_q <= cfg_data[MV_W-1:0];
				CFG_MIN_BATTERY:   min_battery_q   <= cfg_data[MV_W-1:0];
				CFG_FAULT_LIMIT:   fault_limit_q   <= cfg_data[LIMIT_W-1:0];
				CFG_OK_LIMIT:      ok_limit_q      <= cfg_data[LIMIT_W-1:0];
			endcase
		end
	end

	// Stage 1: capture the tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			rate_s1   <= clamp_rate(run_rate);
			period_s1 <= check_period(clamp_rate(run_rate));
			prod_s1   <= prod_in;
			cable_s1  <= cable_low;
		end
	end

	// Finish the scaling: divide by 125 through the reciprocal
	assign scaled  = {{RECIP_W{1'b0}}, prod_s1} * {{PROD_W{1'b0}}, MV_RECIP};
	assign mv_calc = scaled[RECIP_SHIFT +: MV_W];

	// Tick counter, charge state machine and debounce counters
	always_comb begin
		tick_inc    = tick_q + 1'b1;
		check       = tick_inc >= period_s1;
		usb_seen    = (mv_calc > usb_threshold_q) || cable_s1;
		action_d    = ACT_NONE;
		charge_d    = charge_q;
		tick_d      = check ? '0 : tick_inc;
		low_d       = low_q;
		ok_d        = ok_q;
		last_rate_d = rate_s1;
		if (check) begin
			priority if (usb_seen) begin
				low_d = '0;
				ok_d  = '0;
				priority if (charge_q == ST_BAT) begin
					// restart: drop all monitor state back to reset
					action_d    = ACT_RESTART;
					charge_d    = ST_INIT;
					tick_d      = '0;
					last_rate_d = '0;
				end else if (cable_s1) begin
					action_d = ACT_CHARGE;
					charge_d = ST_FULL;
				end else if (charge_q == ST_INIT) begin
					action_d = ACT_USB_REPORT;
					charge_d = ST_USB;
				end else begin
					action_d = ACT_USB_BREATHE;
				end
			end else if (charge_q == ST_FULL || charge_q == ST_INIT) begin
				action_d = ACT_BAT_REPORT;
				charge_d = ST_BAT;
				low_d    = '0;
				ok_d     = '0;
			end else if (mv_calc < min_battery_q) begin
				if (low_q < fault_limit_q) begin
					low_d = low_q + 1'b1;
				end else begin
					action_d = ACT_BAT_FAULT;
					ok_d     = '0;
				end
			end else begin
				low_d = '0;
				if (ok_q < ok_limit_q) begin
					ok_d = ok_q + 1'b1;
				end else begin
					action_d = ACT_BAT_OK;
					charge_d = ST_BAT;
				end
			end
		end
	end

	// Advance the monitor state once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_q    <= ST_INIT;
			tick_q      <= '0;
			low_q       <= '0;
			ok_q        <= '0;
			last_rate_q <= '0;
		end else if (adv_s2) begin
			charge_q    <= charge_d;
			tick_q      <= tick_d;
			low_q       <= low_d;
			ok_q        <= ok_d;
			last_rate_q <= last_rate_d;
		end
	end

	// Stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			action_s2  <= action_d;
			checked_s2 <= check;
			changed_s2 <= rate_s1 != last_rate_q;
			rate_s2    <= rate_s1;
			mv_s2      <= check ? mv_calc : '0;
			charge_s2  <= charge_d;
		end
	end

	assign out_valid        = valid_s2;
	assign action           = action_s2;
	assign power_checked    = checked_s2;
	assign rate_changed     = changed_s2;
	assign clamped_rate     = rate_s2;
	assign battery_mv       = mv_s2;
	assign charge_state_out = charge_s2;

	// Checks
	a_tick_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q < 4'd10)
		else $error("tick counter beyond largest check period");

	a_idle_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !power_checked) |-> (battery_mv == '0 && action == ACT_NONE))
		else $error("tick without power check carries a voltage or action");

	a_restart_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action == ACT_RESTART) |-> (charge_state_out == ST_INIT))
		else $error("restart did not return to init state");

	a_charge_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action == ACT_CHARGE) |-> (charge_state_out == ST_FULL))
		else $error("charge shutdown without battery full state");

	a_rate_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (clamped_rate >= RATE_MIN && clamped_rate <= RATE_MAX))
		else $error("clamped rate out of range");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && check && usb_seen && charge_q == ST_BAT) |=>
			(charge_q == ST_INIT && tick_q == '0 && last_rate_q == '0))
		else $error("restart left monitor state behind");

endmodule
